FILE: design/hsmd_pkg.sv
// Types, constants and the step program shared by the spring-mass-damper block.
`timescale 1ns / 1ps

package hsmd_pkg;

   localparam int DATA_W   = 32;
   localparam int OPA_W    = 49;
   localparam int MAG_W    = 48;
   localparam int PP_W     = 56;
   localparam int PROD_W   = 80;
   localparam int ACC_W    = 52;
   localparam int ACCEL_W  = 48;
   localparam int STEP_W   = 6;
   localparam int INDEX_W  = 2;

   localparam logic [STEP_W-1:0] STEP_LAST = 6'd32;

   localparam logic [DATA_W-1:0] STIFF_RESET   = 32'd655360;
   localparam logic [DATA_W-1:0] INV_INR_RESET = 32'd65536;
   localparam logic [DATA_W-1:0] DAMP_RESET    = 32'd1165;
   localparam logic [DATA_W-1:0] DT_RESET      = 32'd4294967;

   localparam logic [INDEX_W-1:0] REG_STIFF   = 2'd0;
   localparam logic [INDEX_W-1:0] REG_INV_INR = 2'd1;
   localparam logic [INDEX_W-1:0] REG_DAMP    = 2'd2;
   localparam logic [INDEX_W-1:0] REG_DT      = 2'd3;

   localparam logic signed [ACC_W-1:0] SAT_HI = 52'sh0007FFFFFFF;
   localparam logic signed [ACC_W-1:0] SAT_LO = -52'sh00080000000;

   typedef enum logic [2:0] {
      PH_NOP,
      PH_LOAD,
      PH_LO,
      PH_HI,
      PH_END,
      PH_STORE
   } phase_type;

   typedef enum logic [2:0] {
      OPA_MVEL,
      OPA_ANG_POS,
      OPA_WVEL_MVEL,
      OPA_FORCE,
      OPA_ACCEL,
      OPA_X1_ANG,
      OPA_X2_WVEL
   } opa_type;

   typedef enum logic [1:0] {
      COEF_STIFF,
      COEF_INV_INR,
      COEF_DAMP,
      COEF_DT
   } coef_type;

   typedef enum logic [1:0] {
      ACC_ZERO,
      ACC_POS,
      ACC_MVEL,
      ACC_KEEP
   } acc_type;

   typedef enum logic [2:0] {
      DST_X1,
      DST_FORCE,
      DST_ACCEL,
      DST_X2,
      DST_TORQUE
   } dest_type;

   typedef struct packed {
      phase_type phase;
      opa_type   opa;
      coef_type  coef;
      logic      sh32;
      acc_type   acc;
      dest_type  dest;
   } ucode_type;

   typedef struct packed {
      logic      capture;
      logic      commit;
      ucode_type u;
   } ctrl_type;

   typedef struct packed {
      logic rsp_open;
   } status_type;

   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type u;
      u = '{phase: PH_NOP, opa: OPA_MVEL, coef: COEF_DT, sh32: 1'b0,
            acc: ACC_ZERO, dest: DST_X1};
      case (step)
         6'd0: begin
            u.phase = PH_LOAD; u.opa = OPA_MVEL; u.coef = COEF_DT; u.sh32 = 1'b1;
         end
         6'd5: begin
            u.phase = PH_LOAD; u.opa = OPA_ANG_POS; u.coef = COEF_STIFF;
         end
         6'd9: begin
            u.phase = PH_LOAD; u.opa = OPA_WVEL_MVEL; u.coef = COEF_DAMP;
         end
         6'd14: begin
            u.phase = PH_LOAD; u.opa = OPA_FORCE; u.coef = COEF_INV_INR;
         end
         6'd19: begin
            u.phase = PH_LOAD; u.opa = OPA_ACCEL; u.coef = COEF_DT; u.sh32 = 1'b1;
         end
         6'd24: begin
            u.phase = PH_LOAD; u.opa = OPA_X1_ANG; u.coef = COEF_STIFF;
         end
         6'd28: begin
            u.phase = PH_LOAD; u.opa = OPA_X2_WVEL; u.coef = COEF_DAMP;
         end
         6'd1, 6'd6, 6'd10, 6'd15, 6'd20, 6'd25, 6'd29: begin
            u.phase = PH_LO;
         end
         6'd2, 6'd7, 6'd11, 6'd16, 6'd21, 6'd26, 6'd30: begin
            u.phase = PH_HI;
         end
         6'd3: begin
            u.phase = PH_END; u.acc = ACC_POS;
         end
         6'd8, 6'd17, 6'd27: begin
            u.phase = PH_END; u.acc = ACC_ZERO;
         end
         6'd12, 6'd31: begin
            u.phase = PH_END; u.acc = ACC_KEEP;
         end
         6'd22: begin
            u.phase = PH_END; u.acc = ACC_MVEL;
         end
         6'd4: begin
            u.phase = PH_STORE; u.dest = DST_X1;
         end
         6'd13: begin
            u.phase = PH_STORE; u.dest = DST_FORCE;
         end
         6'd18: begin
            u.phase = PH_STORE; u.dest = DST_ACCEL;
         end
         6'd23: begin
            u.phase = PH_STORE; u.dest = DST_X2;
         end
         6'd32: begin
            u.phase = PH_STORE; u.dest = DST_TORQUE;
         end
         default: begin
            u.phase = PH_NOP;
         end
      endcase
      return u;
   endfunction

endpackage

FILE: design/haptic_spring_mass_damper.sv
// Top level of the haptic virtual spring-mass-damper.
// Each req item takes seven products, each as load, low half, high half and accumulate steps
// on two 24x32 multipliers, four saturating stores and one store of the acceleration, handover
// and accept; no new req item is taken until the item in progress has been handed over.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset (synchronous): mass position and velocity go to zero, registers to their defaults.
`timescale 1ns / 1ps

module haptic_spring_mass_damper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // measured_angle [31:0], measured_velocity [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // torque_out [31:0]
   output logic [0:0]  rsp_tuser,   // torque_saturated [0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   hsmd_pkg::ctrl_type   ctrl;
   hsmd_pkg::status_type status;
   logic signed [31:0]   torque_out;
   logic                 torque_saturated;

   hsmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   hsmd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .measured_angle    ($signed(req_tdata[31:0])),
      .measured_velocity ($signed(req_tdata[63:32])),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .torque_out        (torque_out),
      .torque_saturated  (torque_saturated)
   );

   assign rsp_tdata    = torque_out;
   assign rsp_tuser[0] = torque_saturated;

endmodule

FILE: design/hsmd_ctrl.sv
// Sequencer that steps the datapath through one Euler update per item.
`timescale 1ns / 1ps

module hsmd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  hsmd_pkg::status_type  status,
   output hsmd_pkg::ctrl_type    ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [hsmd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                            ready_ff, ready_in;
   logic                            accept;

   assign accept     = req_tvalid & ready_ff;
   assign req_tready = ready_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = '0;
               ready_in = 1'b0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == hsmd_pkg::STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_open) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ready_ff <= ready_in;
      end
   end

   always_comb begin
      ctrl.capture = accept;
      ctrl.commit  = (state_ff == ST_FINISH) && status.rsp_open;
      ctrl.u       = hsmd_pkg::ucode(step_ff);
      if (state_ff != ST_RUN) begin
         ctrl.u.phase = hsmd_pkg::PH_NOP;
      end
   end

endmodule

FILE: design/hsmd_datapath.sv
// Registers, shared multiply unit, accumulator and result register of the block.
`timescale 1ns / 1ps

module hsmd_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  hsmd_pkg::ctrl_type                 ctrl,
   output hsmd_pkg::status_type               status,
   input  logic signed [hsmd_pkg::DATA_W-1:0] measured_angle,
   input  logic signed [hsmd_pkg::DATA_W-1:0] measured_velocity,
   input  logic                               csr_we,
   input  logic [hsmd_pkg::INDEX_W-1:0]       csr_index,
   input  logic [hsmd_pkg::DATA_W-1:0]        csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic signed [hsmd_pkg::DATA_W-1:0] torque_out,
   output logic                               torque_saturated
);

   logic [hsmd_pkg::DATA_W-1:0]          stiff_ff, inv_inr_ff, damp_ff, dt_ff;
   logic signed [hsmd_pkg::DATA_W-1:0]   pos_ff, mvel_ff;
   logic signed [hsmd_pkg::DATA_W-1:0]   angle_ff, wvel_ff;
   logic signed [hsmd_pkg::DATA_W-1:0]   x1_ff, x2_ff, force_ff, torque_ff;
   logic signed [hsmd_pkg::ACCEL_W-1:0]  accel_ff;
   logic                                 clip_ff;
   logic [hsmd_pkg::MAG_W-1:0]           mag_ff;
   logic                                 neg_ff;
   logic                                 sh32_ff;
   logic [hsmd_pkg::DATA_W-1:0]          coef_ff;
   logic [hsmd_pkg::PROD_W-1:0]          prod_ff;
   logic signed [hsmd_pkg::ACC_W-1:0]    acc_ff;
   logic                                 rsp_valid_ff;
   logic signed [hsmd_pkg::DATA_W-1:0]   rsp_torque_ff;
   logic                                 rsp_clip_ff;

   logic signed [hsmd_pkg::OPA_W-1:0]    opa;
   logic signed [hsmd_pkg::OPA_W-1:0]    opa_neg;
   logic [hsmd_pkg::DATA_W-1:0]          coef_sel;
   logic [hsmd_pkg::PP_W-1:0]            lo_pp, hi_pp;
   logic [hsmd_pkg::PROD_W-1:0]          shr;
   logic signed [hsmd_pkg::ACC_W-1:0]    term, term_mag, acc_base, acc_in;
   logic signed [hsmd_pkg::DATA_W-1:0]   sat_val;
   logic                                 sat_clip;

   always_comb begin
      case (ctrl.u.opa)
         hsmd_pkg::OPA_MVEL:      opa = 49'(mvel_ff);
         hsmd_pkg::OPA_ANG_POS:   opa = 49'(angle_ff) - 49'(pos_ff);
         hsmd_pkg::OPA_WVEL_MVEL: opa = 49'(wvel_ff) - 49'(mvel_ff);
         hsmd_pkg::OPA_FORCE:     opa = 49'(force_ff);
         hsmd_pkg::OPA_ACCEL:     opa = 49'(accel_ff);
         hsmd_pkg::OPA_X1_ANG:    opa = 49'(x1_ff) - 49'(angle_ff);
         hsmd_pkg::OPA_X2_WVEL:   opa = 49'(x2_ff) - 49'(wvel_ff);
         default:                 opa = '0;
      endcase
      opa_neg = -opa;
      case (ctrl.u.coef)
         hsmd_pkg::COEF_STIFF:   coef_sel = stiff_ff;
         hsmd_pkg::COEF_INV_INR: coef_sel = inv_inr_ff;
         hsmd_pkg::COEF_DAMP:    coef_sel = damp_ff;
         hsmd_pkg::COEF_DT:      coef_sel = dt_ff;
         default:                coef_sel = '0;
      endcase
   end

   assign lo_pp = 56'(mag_ff[23:0]) * 56'(coef_ff);
   assign hi_pp = 56'(mag_ff[47:24]) * 56'(coef_ff);

   always_comb begin
      shr      = sh32_ff ? (prod_ff >> 32) : (prod_ff >> 16);
      term_mag = $signed({1'b0, shr[hsmd_pkg::ACC_W-2:0]});
      term     = neg_ff ? -term_mag : term_mag;
      case (ctrl.u.acc)
         hsmd_pkg::ACC_ZERO: acc_base = '0;
         hsmd_pkg::ACC_POS:  acc_base = 52'(pos_ff);
         hsmd_pkg::ACC_MVEL: acc_base = 52'(mvel_ff);
         hsmd_pkg::ACC_KEEP: acc_base = acc_ff;
         default:            acc_base = '0;
      endcase
      acc_in = acc_base + term;
   end

   always_comb begin
      sat_clip = 1'b0;
      sat_val  = acc_ff[hsmd_pkg::DATA_W-1:0];
      if (acc_ff > hsmd_pkg::SAT_HI) begin
         sat_clip = 1'b1;
         sat_val  = hsmd_pkg::SAT_HI[hsmd_pkg::DATA_W-1:0];
      end else if (acc_ff < hsmd_pkg::SAT_LO) begin
         sat_clip = 1'b1;
         sat_val  = hsmd_pkg::SAT_LO[hsmd_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff     <= hsmd_pkg::STIFF_RESET;
         inv_inr_ff   <= hsmd_pkg::INV_INR_RESET;
         damp_ff      <= hsmd_pkg::DAMP_RESET;
         dt_ff        <= hsmd_pkg::DT_RESET;
         pos_ff       <= '0;
         mvel_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               hsmd_pkg::REG_STIFF:   stiff_ff   <= csr_wdata;
               hsmd_pkg::REG_INV_INR: inv_inr_ff <= csr_wdata;
               hsmd_pkg::REG_DAMP:    damp_ff    <= csr_wdata;
               hsmd_pkg::REG_DT:      dt_ff      <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (ctrl.commit) begin
            pos_ff       <= x1_ff;
            mvel_ff      <= x2_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         angle_ff <= measured_angle;
         wvel_ff  <= measured_velocity;
      end
      if (ctrl.commit) begin
         rsp_torque_ff <= torque_ff;
         rsp_clip_ff   <= clip_ff;
      end
      case (ctrl.u.phase)
         hsmd_pkg::PH_LOAD: begin
            mag_ff  <= opa[hsmd_pkg::OPA_W-1] ? opa_neg[hsmd_pkg::MAG_W-1:0]
                                              : opa[hsmd_pkg::MAG_W-1:0];
            neg_ff  <= opa[hsmd_pkg::OPA_W-1];
            sh32_ff <= ctrl.u.sh32;
            coef_ff <= coef_sel;
         end
         hsmd_pkg::PH_LO: begin
            prod_ff <= 80'(lo_pp);
         end
         hsmd_pkg::PH_HI: begin
            prod_ff <= prod_ff + {hi_pp, 24'b0};
         end
         hsmd_pkg::PH_END: begin
            acc_ff <= acc_in;
         end
         hsmd_pkg::PH_STORE: begin
            case (ctrl.u.dest)
               hsmd_pkg::DST_X1:    x1_ff    <= sat_val;
               hsmd_pkg::DST_FORCE: force_ff <= sat_val;
               hsmd_pkg::DST_ACCEL: accel_ff <= acc_ff[hsmd_pkg::ACCEL_W-1:0];
               hsmd_pkg::DST_X2:    x2_ff    <= sat_val;
               hsmd_pkg::DST_TORQUE: begin
                  torque_ff <= sat_val;
                  clip_ff   <= sat_clip;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign status.rsp_open  = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign torque_out       = rsp_torque_ff;
   assign torque_saturated = rsp_clip_ff;

endmodule

FILE: sim/haptic_spring_mass_damper_test.sv
// Self-checking testbench for haptic_spring_mass_damper: torque predicted per wheel sample.
`timescale 1ns / 1ps

module haptic_spring_mass_damper_test;
   import hsmd_pkg::*;

   localparam longint Q_HI        = 64'sd2147483647;
   localparam longint Q_LO        = -Q_HI - 1;
   localparam int     STALL_LIMIT = 4000;
   localparam int     HOLD_CYCLES = 400;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   class torque_scoreboard;
      bit [31:0] stiffness;
      bit [31:0] inv_inertia;
      bit [31:0] damping;
      bit [31:0] dt;
      longint    mass_pos;
      longint    mass_vel;
      bit [31:0] torque_q[$];
      bit        clip_q[$];
      int        errors;

      function new();
         stiffness   = STIFF_RESET;
         inv_inertia = INV_INR_RESET;
         damping     = DAMP_RESET;
         dt          = DT_RESET;
         mass_pos    = 0;
         mass_vel    = 0;
         errors      = 0;
      endfunction

      function void set_register(logic [INDEX_W-1:0] index, bit [31:0] value);
         case (index)
            REG_STIFF:   stiffness   = value;
            REG_INV_INR: inv_inertia = value;
            REG_DAMP:    damping     = value;
            REG_DT:      dt          = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return torque_q.size();
      endfunction

      // Exact product, truncated toward zero after the shift.
      function longint scale_trunc(longint a, bit [31:0] coef, int unsigned sh);
         bit [63:0] mag;
         bit [95:0] prod;
         longint    r;
         mag  = (a < 0) ? -a : a;
         prod = {32'd0, mag} * {64'd0, coef};
         prod = prod >> sh;
         r    = longint'(prod[63:0]);
         return (a < 0) ? -r : r;
      endfunction

      function longint clamp32(longint x, output bit clipped);
         clipped = 1'b0;
         if (x > Q_HI) begin
            clipped = 1'b1;
            return Q_HI;
         end
         if (x < Q_LO) begin
            clipped = 1'b1;
            return Q_LO;
         end
         return x;
      endfunction

      function void note_sample(bit [31:0] angle_bits, bit [31:0] vel_bits);
         longint angle, vel, p, v, x1, x2, force_sum, accel, torque;
         bit     scratch, clipped;
         angle  = longint'($signed(angle_bits));
         vel    = longint'($signed(vel_bits));
         p      = mass_pos;
         v      = mass_vel;
         x1     = clamp32(p + scale_trunc(v, dt, 32), scratch);
         force_sum = clamp32(scale_trunc(angle - p, stiffness, 16)
                             + scale_trunc(vel - v, damping, 16), scratch);
         accel  = scale_trunc(force_sum, inv_inertia, 16);
         x2     = clamp32(v + scale_trunc(accel, dt, 32), scratch);
         mass_pos = x1;
         mass_vel = x2;
         torque = clamp32(scale_trunc(x1 - angle, stiffness, 16)
                          + scale_trunc(x2 - vel, damping, 16), clipped);
         torque_q.push_back(torque[31:0]);
         clip_q.push_back(clipped);
      endfunction

      task report_mismatch(string what);
         $display("%0t MISMATCH: %s", $realtime, what);
         errors++;
      endtask

      task check_torque(bit [31:0] torque, bit clipped);
         bit [31:0] want_torque;
         bit        want_clip;
         if (torque_q.size() == 0) begin
            report_mismatch($sformatf("torque %h with no sample pending", torque));
         end else begin
            want_torque = torque_q.pop_front();
            want_clip   = clip_q.pop_front();
            if (torque !== want_torque)
               report_mismatch($sformatf("torque_out %h, want %h", torque, want_torque));
            if (clipped !== want_clip)
               report_mismatch($sformatf("torque_saturated %b, want %b", clipped, want_clip));
         end
      endtask
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [31:0]         rsp_tdata;
   logic [0:0]          rsp_tuser;
   logic                csr_we      = 1'b0;
   logic [INDEX_W-1:0]  csr_index   = REG_STIFF;
   logic [31:0]         csr_wdata   = '0;

   torque_scoreboard sb = new();
   bit hold_request = 1'b0;
   int traj_angle   = 0;
   int idle_cycles  = 0;

   haptic_spring_mass_damper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_sample(req_tdata[31:0], req_tdata[63:32]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_torque(rsp_tdata, rsp_tuser[0]);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : receiver
      rx_mode_type mode;
      int run_left;
      int hold_left;
      int period;
      int tick;
      mode = RX_OPEN;
      run_left = 0;
      hold_left = 0;
      period = 2;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               run_left = $urandom_range(10, 300);
               period = $urandom_range(2, 9);
            end
            run_left--;
            tick++;
            case (mode)
               RX_OPEN:     rsp_tready <= 1'b1;
               RX_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_tready <= ((tick % period) != 0);
               default:     rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_item(bit [31:0] angle, bit [31:0] vel);
      req_tdata  <= {vel, angle};
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic rest_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Leave the write enable high; the caller drops it after the last write.
   task automatic csr_write(logic [INDEX_W-1:0] index, bit [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.set_register(index, value);
      @(posedge clock);
   endtask

   task automatic program_regs(bit [31:0] k, bit [31:0] inv_j, bit [31:0] b, bit [31:0] step);
      csr_write(REG_STIFF, k);
      csr_write(REG_INV_INR, inv_j);
      csr_write(REG_DAMP, b);
      csr_write(REG_DT, step);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bit [31:0] pick_q16();
      bit [31:0] mag;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         1, 2, 3: return $urandom;
         default: begin
            mag = $urandom_range(0, 32'h03FF_FFFF);
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic bit [31:0] pick_reg(bit [31:0] typical_max);
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, typical_max);
      endcase
   endfunction

   task automatic next_sample(output bit [31:0] angle, output bit [31:0] vel);
      int delta;
      if ($urandom_range(0, 9) < 6) begin
         delta = int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         traj_angle += delta;
         angle = traj_angle;
         vel = delta * 1000;
      end else begin
         angle = pick_q16();
         vel = pick_q16();
      end
   endtask

   task automatic send_run(int count);
      bit [31:0] angle, vel;
      int burst_left;
      int n;
      burst_left = $urandom_range(1, 30);
      for (n = 0; n < count; n++) begin
         next_sample(angle, vel);
         send_item(angle, vel);
         burst_left--;
         if (burst_left == 0 && n != count - 1) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
               rest_sender($urandom_range(1, 40));
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h8000_0000);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'h0001_0000, 32'h0000_0000);
      send_item(32'hFFFF_0000, 32'h0064_0000);
      send_item(32'h0000_0001, 32'hFFFF_FFFF);
      settle();

      // every register at full scale: force, state and torque clip
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h8000_0000);
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'h0000_0001, 32'hFFFF_FFFF);
      settle();

      // all registers zero
      program_regs(32'h0, 32'h0, 32'h0, 32'h0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'h1234_5678, 32'h9ABC_DEF0);
      settle();

      for (phase = 0; phase < 10; phase++) begin
         if (phase == 0)
            program_regs(STIFF_RESET, INV_INR_RESET, DAMP_RESET, DT_RESET);
         else if (phase == 1)
            program_regs(pick_reg(32'h0100_0000), pick_reg(32'h0010_0000), 32'h0,
                         pick_reg(32'h1000_0000));
         else
            program_regs(pick_reg(32'h0100_0000), pick_reg(32'h0010_0000),
                         pick_reg(32'h0001_0000), pick_reg(32'h1000_0000));
         if (phase == 3)
            hold_request = 1'b1;
         send_run(200);
         settle();
      end

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: haptic_spring_mass_damper.f
design/hsmd_pkg.sv
design/hsmd_ctrl.sv
design/hsmd_datapath.sv
design/haptic_spring_mass_damper.sv
sim/haptic_spring_mass_damper_test.sv
